// ===== rtl/fcr_pkg.sv =====
// Shared types and constants for the framed command receiver.
`timescale 1ns / 1ps

package fcr_pkg;

	localparam logic [7:0] HEADER_BYTE  = 8'hAA;
	localparam logic [7:0] CMD_FUNCTION = 8'hF3;
	localparam int         MAX_PAYLOAD  = 249;
	localparam int         HEAD_DEPTH   = 7;
	localparam int         IDX_W        = $clog2(HEAD_DEPTH + 1);
	localparam int         HIDX_W       = $clog2(HEAD_DEPTH);
	localparam int         NUM_THRESH   = 6;
	localparam int         CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = CFG_IDX_W'(1);

	localparam logic [7:0] SUB_MODE   = 8'd0;
	localparam logic [7:0] SUB_THRESH = 8'd1;
	localparam logic [7:0] SUB_PAGE   = 8'd2;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TARGET  = 3'd1,
		PH_FUNC    = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_SUM     = 3'd5,
		PH_SOS     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_MODE   = 2'd0,
		KIND_THRESH = 2'd1,
		KIND_PAGE   = 2'd2
	} kind_t;

	typedef struct packed {
		logic                            valid;
		kind_t                           kind;
		logic [7:0]                      mode;
		logic [7:0]                      old_mode;
		logic [7:0]                      page;
		logic [NUM_THRESH-1:0][7:0]      thresh;
	} result_t;

endpackage

// ===== rtl/fcr_parser.sv =====
// Frame parser: header/address/length sequencing, checksums and command decode.
`timescale 1ns / 1ps

module fcr_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [7:0]       rx_byte,
	input  logic [7:0]       own_address,
	input  logic [7:0]       broadcast_address,
	output fcr_pkg::result_t res
);
	import fcr_pkg::*;

	phase_t            phase_q, phase_d;
	logic [7:0]        left_q, left_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [7:0]        func_q, func_d;
	logic [7:0]        sum_q, sum_d;
	logic [7:0]        sos_q, sos_d;
	logic [7:0]        rsum_q, rsum_d;
	logic [7:0]        mode_q, mode_d;
	logic [7:0]        old_q, old_d;
	logic [7:0]        page_q, page_d;
	logic [7:0]        head_q [HEAD_DEPTH];
	logic              head_we;
	logic [7:0]        sum_add;
	logic [7:0]        sos_add;
	logic              fire;
	kind_t             kind;

	assign sum_add = sum_q + rx_byte;
	assign sos_add = sos_q + sum_add;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		idx_d   = idx_q;
		func_d  = func_q;
		sum_d   = sum_q;
		sos_d   = sos_q;
		rsum_d  = rsum_q;
		mode_d  = mode_q;
		old_d   = old_q;
		page_d  = page_q;
		head_we = 1'b0;
		fire    = 1'b0;
		kind    = KIND_MODE;
		if (en) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (rx_byte == HEADER_BYTE) begin
						sum_d   = HEADER_BYTE;
						sos_d   = HEADER_BYTE;
						phase_d = PH_TARGET;
					end
				end
				PH_TARGET: begin
					if (rx_byte == own_address || rx_byte == broadcast_address) begin
						sum_d   = sum_add;
						sos_d   = sos_add;
						phase_d = PH_FUNC;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_FUNC: begin
					func_d  = rx_byte;
					sum_d   = sum_add;
					sos_d   = sos_add;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					if (rx_byte <= 8'(MAX_PAYLOAD)) begin
						left_d  = rx_byte;
						idx_d   = '0;
						sum_d   = sum_add;
						sos_d   = sos_add;
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_PAYLOAD: begin
					// A zero length swallows the byte after the length field.
					if (left_q == 8'd0) begin
						phase_d = PH_IDLE;
					end else begin
						// The index saturates once the head store is full.
						if (idx_q < IDX_W'(HEAD_DEPTH)) begin
							head_we = 1'b1;
							idx_d   = idx_q + IDX_W'(1);
						end
						left_d = left_q - 8'd1;
						sum_d  = sum_add;
						sos_d  = sos_add;
						if (left_q == 8'd1) begin
							phase_d = PH_SUM;
						end
					end
				end
				PH_SUM: begin
					rsum_d  = rx_byte;
					phase_d = PH_SOS;
				end
				PH_SOS: begin
					phase_d = PH_IDLE;
					if (rsum_q == sum_q && rx_byte == sos_q && func_q == CMD_FUNCTION
						&& idx_q >= IDX_W'(1)) begin
						case (head_q[0])
							SUB_MODE: begin
								if (idx_q >= IDX_W'(2)) begin
									if (head_q[1] != mode_q) begin
										old_d = mode_q;
									end
									mode_d = head_q[1];
									fire   = 1'b1;
									kind   = KIND_MODE;
								end
							end
							SUB_THRESH: begin
								if (idx_q >= IDX_W'(HEAD_DEPTH)) begin
									fire = 1'b1;
									kind = KIND_THRESH;
								end
							end
							SUB_PAGE: begin
								if (idx_q >= IDX_W'(2)) begin
									page_d = head_q[1];
									fire   = 1'b1;
									kind   = KIND_PAGE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res.valid    = fire;
		res.kind     = kind;
		res.mode     = mode_d;
		res.old_mode = old_d;
		res.page     = page_d;
		for (int i = 0; i < NUM_THRESH; i++) begin
			res.thresh[i] = (kind == KIND_THRESH) ? head_q[i + 1] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			idx_q  <= '0;
			func_q <= '0;
			sum_q  <= '0;
			sos_q  <= '0;
			rsum_q <= '0;
			mode_q <= '0;
			old_q  <= '0;
			page_q <= '0;
		end else begin
			left_q <= left_d;
			idx_q  <= idx_d;
			func_q <= func_d;
			sum_q  <= sum_d;
			sos_q  <= sos_d;
			rsum_q <= rsum_d;
			mode_q <= mode_d;
			old_q  <= old_d;
			page_q <= page_d;
		end
	end

	// Payload head entries are only read after being written in the same frame.
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_q[idx_q[HIDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

// ===== rtl/framed_command_receiver.sv =====
// Framed command receiver top level: input stage, parser and output buffering.
//
// Bytes enter on the s_axis channel, one per transaction, and are parsed into
// frames of header 0xAA, target, function, length, payload, sum and
// sum-of-sums. A checked frame with function 0xF3, a known subcommand and
// enough payload bytes produces one result transaction on the m_axis channel.
// The own and broadcast target addresses are set through the cfg write port;
// write them only while no byte is in flight (the block does not enforce it).
// A result is registered when the sum-of-sums byte leaves the input register
// through the parser; it lands in the result register, or in the skid buffer
// while the result register is stalled.
// Throughput: one byte per cycle while the skid buffer is free; each byte needs
// a single pass of parser logic between the input and result registers.
// The output has a result register plus a one-entry skid buffer. When the
// downstream stalls, bytes keep flowing until the skid buffer holds a result;
// then s_axis_tready drops only while a byte waits in the input register.
// Reset puts the parser in its idle state, empties both output entries, sets
// the own address to 0x00, the broadcast address to 0xFF and the held mode,
// previous mode and page to zero.
`timescale 1ns / 1ps

module framed_command_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [7:0] mode_value, [15:8] previous_mode, [23:16] page_number,
	// [31:24] thresh_l_low, [39:32] thresh_l_high, [47:40] thresh_a_low,
	// [55:48] thresh_a_high, [63:56] thresh_b_low, [71:64] thresh_b_high
	output logic [71:0]                   m_axis_tdata,
	output logic [1:0]                    m_axis_tuser,  // [1:0] result_kind
	input  logic                          cfg_we,
	input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import fcr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic [7:0] own_q;
	logic [7:0] bcast_q;
	result_t    res;
	result_t    out_q;
	result_t    skid_q;
	logic       out_valid_q;
	logic       skid_valid_q;
	logic       take;

	// A byte leaves the input register only when the skid entry is free, so a
	// result it raises always finds room.
	assign advance       = valid_s1 && !skid_valid_q;
	assign s_axis_tready = !valid_s1 || advance;
	assign take          = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q   <= 8'h00;
			bcast_q <= 8'hFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OWN_ADDR:   own_q   <= cfg_data;
				REG_BCAST_ADDR: bcast_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	fcr_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (advance),
		.rx_byte           (byte_s1),
		.own_address       (own_q),
		.broadcast_address (bcast_q),
		.res               (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res.valid;
			end
		end else if (res.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else begin
				out_q <= res;
			end
		end else if (res.valid) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {out_q.thresh, out_q.page, out_q.old_mode, out_q.mode};

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	a_result_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !skid_valid_q)
		else $error("parser raised a result with both output entries full");

	a_result_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.kind == KIND_MODE || res.kind == KIND_THRESH
			|| res.kind == KIND_PAGE))
		else $error("parser raised a result of an unknown kind");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && skid_valid_q && out_valid_q))
		else $error("input stalled while output buffering had room");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && take) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry did not move into the output register");

endmodule
